// ===== design/tapwm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tapwm_pkg
// Shared types and constants for the thruster allocation and PWM block.
// ----------------------------------------------------------------------------
package tapwm_pkg;

  localparam int WRENCH_AXES = 6;
  localparam int THR_FULL    = 65536;
  localparam logic [16:0] PHASE_MAX = 17'h1FFFF;

  typedef enum logic [2:0] {
    ACT_LOAD_FULL  = 3'd0,
    ACT_LOAD_RCS   = 3'd1,
    ACT_ALLOC_FULL = 3'd2,
    ACT_ALLOC_RCS  = 3'd3,
    ACT_TICK       = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    OP_LOAD_FULL,
    OP_LOAD_RCS,
    OP_ALLOC_FULL,
    OP_ALLOC_RCS,
    OP_TICK,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_MASK   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_COUNT  = 2'd0,
    REG_RCS    = 2'd1,
    REG_PERIOD = 2'd2,
    REG_FRAC   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [4:0]  thruster_count;
    logic [15:0] rcs_mask;
    logic [15:0] pwm_period;
    logic [16:0] min_duty_fraction;
  } cfg_t;

  typedef struct packed {
    op_t                              op;
    logic [3:0]                       thruster_index;
    logic [2:0]                       axis_index;
    logic [31:0]                      coef_value;
    logic [WRENCH_AXES-1:0][31:0]     wrench;
    logic [15:0]                      time_step;
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_LOAD,
    B_ARD,
    B_AMUL,
    B_ASUM,
    B_ACLP,
    B_AEMIT,
    B_MRD,
    B_MCMP,
    B_CUT,
    B_TRD,
    B_TPH,
    B_TFIRE,
    B_TEMIT
  } bstate_t;

endpackage
`default_nettype wire

// ===== design/tapwm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tapwm_front
// Accepts input beats, decodes the action and pushes commands to the queue.
// ----------------------------------------------------------------------------
module tapwm_front (
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2:0]            action,
  input  wire logic [3:0]            thruster_index,
  input  wire logic [2:0]            axis_index,
  input  wire logic signed [31:0]    coef_value,
  input  wire logic signed [31:0]    force_x,
  input  wire logic signed [31:0]    force_y,
  input  wire logic signed [31:0]    force_z,
  input  wire logic signed [31:0]    torque_x,
  input  wire logic signed [31:0]    torque_y,
  input  wire logic signed [31:0]    torque_z,
  input  wire logic [15:0]           time_step,
  input  wire logic                  q_full,
  output logic                       q_push,
  output tapwm_pkg::cmd_t            q_data
);
  import tapwm_pkg::*;

  op_t op;

  always_comb begin
    case (action)
      ACT_LOAD_FULL:  op = OP_LOAD_FULL;
      ACT_LOAD_RCS:   op = OP_LOAD_RCS;
      ACT_ALLOC_FULL: op = OP_ALLOC_FULL;
      ACT_ALLOC_RCS:  op = OP_ALLOC_RCS;
      ACT_TICK:       op = OP_TICK;
      default:        op = OP_NONE;
    endcase
  end

  assign in_ready = !q_full;
  // drop unused actions: they produce nothing
  assign q_push   = in_valid && !q_full && (op != OP_NONE);

  always_comb begin
    q_data.op             = op;
    q_data.thruster_index = thruster_index;
    q_data.axis_index     = axis_index;
    q_data.coef_value     = coef_value;
    q_data.wrench[0]      = force_x;
    q_data.wrench[1]      = force_y;
    q_data.wrench[2]      = force_z;
    q_data.wrench[3]      = torque_x;
    q_data.wrench[4]      = torque_y;
    q_data.wrench[5]      = torque_z;
    q_data.time_step      = time_step;
  end

endmodule
`default_nettype wire

// ===== design/tapwm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tapwm_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module tapwm_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire tapwm_pkg::cmd_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output tapwm_pkg::cmd_t      head
);
  import tapwm_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/tapwm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tapwm_back
// Executes commands: coefficient loads, per-thruster allocation with six
// parallel multiplies, and the two-pass PWM tick. Drives the result register.
// ----------------------------------------------------------------------------
module tapwm_back #(
  parameter int MAX_THRUSTERS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tapwm_pkg::cfg_t cfg,
  input  wire logic            q_valid,
  input  wire tapwm_pkg::cmd_t q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [1:0]           kind,
  output logic [3:0]           report_index,
  output logic [16:0]          throttle_value,
  output logic [15:0]          firing_mask,
  output logic                 last
);
  import tapwm_pkg::*;

  localparam int AW = (MAX_THRUSTERS > 1) ? $clog2(MAX_THRUSTERS) : 1;
  localparam int CW = $clog2(MAX_THRUSTERS + 1);
  localparam int MW = AW + 1;

  bstate_t state, state_next;
  cmd_t    cmd;
  logic [CW-1:0] idx;
  logic [CW-1:0] n;
  logic [CW-1:0] n_calc;
  logic          idx_last;
  logic          out_free;

  logic signed [31:0] coef_rd [WRENCH_AXES];
  logic signed [63:0] prod    [WRENCH_AXES];
  logic signed [64:0] psum    [3];
  logic signed [66:0] total;
  logic signed [42:0] hi;
  logic [16:0]        thr_calc;
  logic               in_rcs;

  logic [16:0] mx;
  logic [33:0] cut;
  logic [16:0] thr_rd;
  logic [16:0] ph_rd;
  logic [16:0] ph_new;
  logic [17:0] ph_sum;
  logic [17:0] ph_wrap;
  logic [16:0] ph_calc;
  logic [15:0] mask;
  logic        is_off;
  logic        fires;

  logic [AW-1:0]  ra;
  logic [MW-1:0]  tab_ra;
  logic [MW-1:0]  tab_wa;
  logic           tab_we;
  logic           load_ok;

  logic [16:0]    thr_mem [MAX_THRUSTERS];
  logic [MAX_THRUSTERS-1:0] thr_vld;
  logic [16:0]    ph_mem  [MAX_THRUSTERS];
  logic [MAX_THRUSTERS-1:0] ph_vld;
  logic           thr_we;
  logic           ph_we;
  logic [16:0]    ph_wd;
  logic           out_load;
  logic [16:0]    throttle_value_hold;

  assign n_calc   = (32'(cfg.thruster_count) > MAX_THRUSTERS) ? CW'(MAX_THRUSTERS)
                                                              : CW'(cfg.thruster_count);
  assign idx_last = (CW'(idx + 1'b1) == n);
  assign out_free = !out_valid || out_ready;
  assign ra       = idx[AW-1:0];

  // coefficient banks, one per axis, rows split by table
  assign tab_ra  = {cmd.op == OP_ALLOC_RCS, ra};
  assign tab_wa  = {cmd.op == OP_LOAD_RCS, AW'(cmd.thruster_index)};
  assign load_ok = (32'(cmd.thruster_index) < MAX_THRUSTERS) &&
                   (32'(cmd.axis_index) < WRENCH_AXES);
  assign tab_we  = (state == B_LOAD) && out_free && load_ok;

  for (genvar a = 0; a < WRENCH_AXES; a++) begin : g_bank
    logic [31:0] mem [2*MAX_THRUSTERS];
    always_ff @(posedge clk) begin
      if (tab_we && (cmd.axis_index == 3'(a))) begin
        mem[tab_wa] <= cmd.coef_value;
      end
      coef_rd[a] <= mem[tab_ra];
    end
  end

  // dot product, sum and clamp
  assign total = 67'(psum[0]) + 67'(psum[1]) + 67'(psum[2]);
  assign hi    = 43'(total >>> 24);
  assign in_rcs = (32'(idx) < 16) && cfg.rcs_mask[4'(idx)];

  always_comb begin
    if (cmd.op == OP_ALLOC_RCS && !in_rcs) begin
      thr_calc = 17'd0;
    end else if (hi < 0) begin
      thr_calc = 17'd0;
    end else if (hi > 43'(THR_FULL)) begin
      thr_calc = 17'(THR_FULL);
    end else begin
      thr_calc = hi[16:0];
    end
  end

  // phase update
  assign is_off  = {thr_rd, 16'd0} < {16'd0, cut} ? 1'b1 : 1'b0;
  assign ph_sum  = {1'b0, ph_rd} + {2'b00, cmd.time_step};
  assign ph_wrap = (ph_sum >= {2'b00, cfg.pwm_period}) ? ph_sum - {2'b00, cfg.pwm_period}
                                                       : ph_sum;
  assign ph_calc = (ph_wrap > {1'b0, PHASE_MAX}) ? PHASE_MAX : ph_wrap[16:0];
  assign fires   = {ph_new, 16'd0} < (33'(thr_rd) * 33'(cfg.pwm_period));

  // throttle and phase stores, zero until written
  assign thr_we = (state == B_ACLP);
  assign ph_we  = ((state == B_TPH) && is_off) || (state == B_TFIRE);
  assign ph_wd  = (state == B_TFIRE) ? ph_new : 17'd0;

  always_ff @(posedge clk) begin
    if (thr_we) thr_mem[ra] <= thr_calc;
    if (ph_we)  ph_mem[ra]  <= ph_wd;
    thr_rd <= thr_vld[ra] ? thr_mem[ra] : 17'd0;
    ph_rd  <= ph_vld[ra]  ? ph_mem[ra]  : 17'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_vld <= '0;
      ph_vld  <= '0;
    end else begin
      if (thr_we) thr_vld[ra] <= 1'b1;
      if (ph_we)  ph_vld[ra]  <= 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          case (q_head.op)
            OP_LOAD_FULL, OP_LOAD_RCS:   state_next = B_LOAD;
            OP_ALLOC_FULL, OP_ALLOC_RCS: state_next = (n_calc == '0) ? B_IDLE : B_ARD;
            OP_TICK:                     state_next = (n_calc == '0) ? B_TEMIT : B_MRD;
            default:                     state_next = B_IDLE;
          endcase
        end
      end
      B_LOAD:  if (out_free) state_next = B_IDLE;
      B_ARD:   state_next = B_AMUL;
      B_AMUL:  state_next = B_ASUM;
      B_ASUM:  state_next = B_ACLP;
      B_ACLP:  state_next = B_AEMIT;
      B_AEMIT: if (out_free) state_next = idx_last ? B_IDLE : B_ARD;
      B_MRD:   state_next = B_MCMP;
      B_MCMP:  state_next = idx_last ? B_CUT : B_MRD;
      B_CUT:   state_next = B_TRD;
      B_TRD:   state_next = B_TPH;
      B_TPH: begin
        if (!is_off)       state_next = B_TFIRE;
        else if (idx_last) state_next = B_TEMIT;
        else               state_next = B_TRD;
      end
      B_TFIRE: state_next = idx_last ? B_TEMIT : B_TRD;
      B_TEMIT: if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = (state == B_IDLE) && q_valid;
    out_load = 1'b0;
    case (state)
      B_LOAD, B_AEMIT, B_TEMIT: out_load = out_free;
      default:                  out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          cmd  <= q_head;
          n    <= n_calc;
          idx  <= '0;
          mx   <= 17'd0;
          mask <= 16'd0;
        end
      end
      B_AMUL: begin
        for (int a = 0; a < WRENCH_AXES; a++) begin
          prod[a] <= coef_rd[a] * $signed(cmd.wrench[a]);
        end
      end
      B_ASUM: begin
        for (int k = 0; k < 3; k++) begin
          psum[k] <= 65'(prod[2*k]) + 65'(prod[2*k+1]);
        end
      end
      B_ACLP: throttle_value_hold <= thr_calc;
      B_AEMIT: if (out_free && !idx_last) idx <= idx + 1'b1;
      B_MCMP: begin
        if (thr_rd > mx) mx <= thr_rd;
        idx <= idx_last ? '0 : idx + 1'b1;
      end
      B_CUT: cut <= 34'(cfg.min_duty_fraction) * 34'(mx);
      B_TPH: begin
        ph_new <= ph_calc;
        if (is_off && !idx_last) idx <= idx + 1'b1;
      end
      B_TFIRE: begin
        if (fires && (32'(idx) < 16)) mask[4'(idx)] <= 1'b1;
        if (!idx_last) idx <= idx + 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      case (state)
        B_LOAD: begin
          kind           <= KIND_ACK;
          report_index   <= cmd.thruster_index;
          throttle_value <= 17'd0;
          firing_mask    <= 16'd0;
          last           <= 1'b1;
        end
        B_AEMIT: begin
          kind           <= KIND_REPORT;
          report_index   <= 4'(idx);
          throttle_value <= throttle_value_hold;
          firing_mask    <= 16'd0;
          last           <= idx_last;
        end
        default: begin
          kind           <= KIND_MASK;
          report_index   <= 4'd0;
          throttle_value <= 17'd0;
          firing_mask    <= mask;
          last           <= 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/thruster_allocation_pwm_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thruster_allocation_pwm_unit
// Thruster allocation from a wrench and PWM firing, with config registers.
// ----------------------------------------------------------------------------
//  channel | handshake           | carries
//  --------+---------------------+-------------------------------------------
//  in      | in_valid/in_ready   | action, load fields, wrench, time_step
//  out     | out_valid/out_ready | kind, report_index, throttle, mask, last
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A load writes one coefficient and acknowledges it. Allocate runs the read,
// multiply, add and clamp steps of the shared dot-product unit for each
// thruster in use. Tick runs a max pass over the thrusters, then an update
// pass. A two-entry queue lets input run ahead of the back.
// Synchronous reset clears control, config and store valid bits; a stalled
// out channel holds the back at its next result.
// ----------------------------------------------------------------------------
module thruster_allocation_pwm_unit #(
  parameter int MAX_THRUSTERS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         action,
  input  wire logic [3:0]         thruster_index,
  input  wire logic [2:0]         axis_index,
  input  wire logic signed [31:0] coef_value,
  input  wire logic signed [31:0] force_x,
  input  wire logic signed [31:0] force_y,
  input  wire logic signed [31:0] force_z,
  input  wire logic signed [31:0] torque_x,
  input  wire logic signed [31:0] torque_y,
  input  wire logic signed [31:0] torque_z,
  input  wire logic [15:0]        time_step,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              kind,
  output logic [3:0]              report_index,
  output logic [16:0]             throttle_value,
  output logic [15:0]             firing_mask,
  output logic                    last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [16:0]        cfg_data
);
  import tapwm_pkg::*;

  cfg_t cfg;
  logic q_full;
  logic q_push;
  cmd_t q_data;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thruster_count    <= 5'd0;
      cfg.rcs_mask          <= 16'd0;
      cfg.pwm_period        <= 16'd1000;
      cfg.min_duty_fraction <= 17'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COUNT:  cfg.thruster_count    <= cfg_data[4:0];
        REG_RCS:    cfg.rcs_mask          <= cfg_data[15:0];
        REG_PERIOD: cfg.pwm_period        <= cfg_data[15:0];
        REG_FRAC:   cfg.min_duty_fraction <= cfg_data;
        default:    ;
      endcase
    end
  end

  tapwm_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .thruster_index (thruster_index),
    .axis_index     (axis_index),
    .coef_value     (coef_value),
    .force_x        (force_x),
    .force_y        (force_y),
    .force_z        (force_z),
    .torque_x       (torque_x),
    .torque_y       (torque_y),
    .torque_z       (torque_z),
    .time_step      (time_step),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_data)
  );

  tapwm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  tapwm_back #(
    .MAX_THRUSTERS (MAX_THRUSTERS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .report_index   (report_index),
    .throttle_value (throttle_value),
    .firing_mask    (firing_mask),
    .last           (last)
  );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the thruster allocation and PWM unit: a directed
// table followed by random coefficient loads, allocations and PWM ticks,
// with every result compared against an in-bench throttle and firing model.
// ----------------------------------------------------------------------------
module tb_top;
  import tapwm_pkg::*;

  localparam int NTHR       = 16;
  localparam int SETTLE     = 200;
  localparam int WDOG_LIMIT = 20000;
  localparam int HOLD_LEN   = 400;
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]       act;
    logic [3:0]       tidx;
    logic [2:0]       ax;
    logic [31:0]      coef;
    logic [5:0][31:0] wr;
    logic [15:0]      dt;
  } beat_t;

  typedef struct packed {
    logic [1:0]  knd;
    logic [3:0]  idx;
    logic [16:0] thr;
    logic [15:0] mask;
    logic        lst;
  } res_t;

  typedef struct {
    bit          is_cfg;
    cfg_reg_t    reg_sel;
    logic [16:0] reg_val;
    beat_t       b;
    int          ntyped;
    res_t        typed;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_ready;
  logic [2:0] action = 0;
  logic [3:0] thruster_index = 0;
  logic [2:0] axis_index = 0;
  logic signed [31:0] coef_value = 0;
  logic signed [31:0] force_x = 0, force_y = 0, force_z = 0;
  logic signed [31:0] torque_x = 0, torque_y = 0, torque_z = 0;
  logic [15:0] time_step = 0;
  logic out_valid, out_ready = 0;
  logic [1:0] kind;
  logic [3:0] report_index;
  logic [16:0] throttle_value;
  logic [15:0] firing_mask;
  logic last;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [16:0] cfg_data = 0;

  thruster_allocation_pwm_unit DUT (.*);

  always #5 clk = ~clk;

  // model state
  logic signed [31:0] full_coef [NTHR*6];
  logic signed [31:0] rcs_coef  [NTHR*6];
  bit                 full_ok   [NTHR*6];
  bit                 rcs_ok    [NTHR*6];
  logic [16:0]        thr_mem   [NTHR];
  logic [16:0]        phase_mem [NTHR];
  logic [4:0]  m_count;
  logic [15:0] m_rcs;
  logic [15:0] m_period;
  logic [16:0] m_frac;

  res_t expected_results [$];
  res_t pending [$];
  int   errors = 0;
  int   burst_left = 0;
  bit   hold_req = 0;
  int   idle_cycles = 0;
  row_t rows [$];

  function automatic int active_n();
    return (m_count > NTHR) ? NTHR : int'(m_count);
  endfunction

  function automatic logic [16:0] dot_throttle(bit use_rcs, int row, beat_t b);
    logic signed [71:0] acc;
    logic signed [31:0] c;
    acc = 0;
    for (int a = 0; a < 6; a++) begin
      c = use_rcs ? rcs_coef[row*6+a] : full_coef[row*6+a];
      acc += 72'(longint'(c) * longint'($signed(b.wr[a])));
    end
    acc = acc >>> 24;
    if (acc < 0) return 17'd0;
    if (acc > THR_FULL) return 17'(THR_FULL);
    return acc[16:0];
  endfunction

  task automatic predict(beat_t b);
    int n;
    longint unsigned mx, cut, ph;
    logic [16:0] t;
    logic [15:0] fire;
    n = active_n();
    pending.delete();
    if (b.act == ACT_LOAD_FULL || b.act == ACT_LOAD_RCS) begin
      if (b.ax < 6) begin
        if (b.act == ACT_LOAD_FULL) begin
          full_coef[b.tidx*6+b.ax] = b.coef;
          full_ok[b.tidx*6+b.ax] = 1;
        end else begin
          rcs_coef[b.tidx*6+b.ax] = b.coef;
          rcs_ok[b.tidx*6+b.ax] = 1;
        end
      end
      pending.insert(pending.size(), res_t'{KIND_ACK, b.tidx, 17'd0, 16'd0, 1'b1});
    end else if (b.act == ACT_ALLOC_FULL || b.act == ACT_ALLOC_RCS) begin
      for (int i = 0; i < n; i++) begin
        if (b.act == ACT_ALLOC_FULL) t = dot_throttle(0, i, b);
        else if (m_rcs[i]) t = dot_throttle(1, i, b);
        else t = 0;
        thr_mem[i] = t;
        pending.insert(pending.size(),
                       res_t'{KIND_REPORT, 4'(i), t, 16'd0, 1'(i + 1 == n)});
      end
    end else if (b.act == ACT_TICK) begin
      mx = 0;
      fire = 0;
      for (int i = 0; i < n; i++) if (thr_mem[i] > mx) mx = thr_mem[i];
      cut = longint'(m_frac) * mx;
      for (int i = 0; i < n; i++) begin
        if (longint'(thr_mem[i]) * 65536 < cut) begin
          phase_mem[i] = 0;
        end else begin
          ph = longint'(phase_mem[i]) + b.dt;
          if (ph >= m_period) ph -= m_period;
          if (ph > PHASE_MAX) ph = PHASE_MAX;
          phase_mem[i] = ph[16:0];
          if (ph * 65536 < longint'(thr_mem[i]) * m_period) fire[i] = 1;
        end
      end
      pending.insert(pending.size(), res_t'{KIND_MASK, 4'd0, 17'd0, fire, 1'b1});
    end
  endtask

  // drive one beat; payload changes only once the previous beat is taken
  task automatic send_beat(beat_t b, int ntyped, res_t typed);
    action <= b.act;
    thruster_index <= b.tidx;
    axis_index <= b.ax;
    coef_value <= b.coef;
    force_x <= b.wr[0];
    force_y <= b.wr[1];
    force_z <= b.wr[2];
    torque_x <= b.wr[3];
    torque_y <= b.wr[4];
    torque_z <= b.wr[5];
    time_step <= b.dt;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    predict(b);
    if (ntyped == 0) pending.delete();
    if (ntyped == 1) pending = '{typed};
    foreach (pending[k]) expected_results.insert(expected_results.size(), pending[k]);
  endtask

  task automatic sender_gap();
    int g;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    g = $urandom_range(1, 8);
    burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
    in_valid <= 0;
    repeat (g) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t sel, logic [16:0] val);
    cfg_index <= sel;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (sel)
      REG_COUNT:  m_count = val[4:0];
      REG_RCS:    m_rcs = val[15:0];
      REG_PERIOD: m_period = val[15:0];
      REG_FRAC:   m_frac = val;
      default:    ;
    endcase
    @(posedge clk);
  endtask

  function automatic beat_t mk(logic [2:0] act, logic [3:0] t, logic [2:0] ax,
                               logic [31:0] coef, logic [31:0] w, logic [15:0] dt);
    beat_t b;
    b.act = act; b.tidx = t; b.ax = ax; b.coef = coef; b.dt = dt;
    for (int a = 0; a < 6; a++) b.wr[a] = w;
    return b;
  endfunction

  function automatic void add(beat_t b, int ntyped, res_t typed);
    row_t r;
    r.is_cfg = 0; r.reg_sel = REG_COUNT; r.reg_val = 0;
    r.b = b; r.ntyped = ntyped; r.typed = typed;
    rows.insert(rows.size(), r);
  endfunction

  function automatic void add_cfg(cfg_reg_t sel, logic [16:0] val);
    row_t r;
    r.b = '0; r.typed = '0;
    r.is_cfg = 1; r.reg_sel = sel; r.reg_val = val; r.ntyped = -1;
    rows.insert(rows.size(), r);
  endfunction

  function automatic logic [31:0] rand_fix();
    logic signed [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 15) == 0) return v;
    return v >>> $urandom_range(6, 24);
  endfunction

  // pick a random beat; an allocation whose rows are not all loaded yet
  // becomes a load of the first missing coefficient
  function automatic beat_t next_beat();
    beat_t b;
    int sel, n;
    b.act = ACT_TICK;
    b.tidx = $urandom;
    b.ax = $urandom;
    b.coef = rand_fix();
    for (int a = 0; a < 6; a++) b.wr[a] = rand_fix();
    b.dt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
    sel = $urandom_range(0, 99);
    n = active_n();
    if (sel < 35) b.act = ACT_ALLOC_FULL;
    else if (sel < 55) b.act = ACT_ALLOC_RCS;
    else if (sel < 85) b.act = ACT_TICK;
    else if (sel < 95) b.act = ($urandom_range(0, 1) == 0) ? ACT_LOAD_FULL : ACT_LOAD_RCS;
    else b.act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    if (b.act == ACT_ALLOC_FULL || b.act == ACT_ALLOC_RCS) begin
      for (int i = n - 1; i >= 0; i--)
        for (int a = 5; a >= 0; a--)
          if (b.act == ACT_ALLOC_FULL ? !full_ok[i*6+a] : (m_rcs[i] && !rcs_ok[i*6+a])) begin
            b.tidx = 4'(i);
            b.ax = 3'(a);
          end
      for (int i = 0; i < n; i++)
        for (int a = 0; a < 6; a++)
          if (b.act == ACT_ALLOC_FULL ? !full_ok[i*6+a] : (m_rcs[i] && !rcs_ok[i*6+a])) begin
            b.act = (b.act == ACT_ALLOC_FULL) ? ACT_LOAD_FULL : ACT_LOAD_RCS;
            return b;
          end
    end
    return b;
  endfunction

  // receiver: stall pattern of its own, plus one long hold on request
  initial begin
    int seg, mode;
    seg = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      if (seg == 0) begin
        seg = $urandom_range(10, 80);
        mode = $urandom_range(0, 2);
      end
      seg--;
      case (mode)
        0: out_ready <= 1;
        1: out_ready <= ($urandom_range(0, 1) == 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d idx=%0d thr=%0d mask=%h last=%0d",
                 $time, kind, report_index, throttle_value, firing_mask, last);
      end else begin
        e = expected_results.pop_front();
        if ({kind, report_index, throttle_value, firing_mask, last} != e) begin
          errors++;
          $display("%0t: mismatch expected kind=%0d idx=%0d thr=%0d mask=%h last=%0d",
                   $time, e.knd, e.idx, e.thr, e.mask, e.lst);
          $display("%0t:          actual   kind=%0d idx=%0d thr=%0d mask=%h last=%0d",
                   $time, kind, report_index, throttle_value, firing_mask, last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("thruster_allocation_pwm_unit verification failed");
      $finish;
    end
  end

  initial begin
    res_t none;
    logic [4:0] counts [8];
    none = '0;
    counts = '{5'd2, 5'd0, 5'd4, 5'd1, 5'd8, 5'd16, 5'd31, 5'd5};
    m_count = 0; m_rcs = 0; m_period = 1000; m_frac = 0;
    for (int i = 0; i < NTHR; i++) begin
      thr_mem[i] = 0;
      phase_mem[i] = 0;
    end
    for (int i = 0; i < NTHR*6; i++) begin
      full_ok[i] = 0;
      rcs_ok[i] = 0;
      full_coef[i] = 0;
      rcs_coef[i] = 0;
    end

    // directed table: spare actions and allocations with zero thrusters give nothing; a tick gives an empty mask
    add(mk(ACT_SPARE_LO, 0, 0, 0, 0, 0), 0, none);
    add(mk(ACT_SPARE_HI, 4'hF, 3'h7, '1, '1, '1), 0, none);
    add(mk(ACT_ALLOC_FULL, 0, 0, 0, 32'h7FFFFFFF, 0), 0, none);
    add(mk(ACT_ALLOC_RCS, 0, 0, 0, 32'h80000000, 0), 0, none);
    add(mk(ACT_TICK, 0, 0, 0, 0, 16'hFFFF), 1, '{KIND_MASK, 4'd0, 17'd0, 16'd0, 1'b1});
    add(mk(ACT_LOAD_FULL, 0, 0, 32'h7FFFFFFF, 0, 0), 1, '{KIND_ACK, 4'd0, 17'd0, 16'd0, 1'b1});
    add(mk(ACT_LOAD_FULL, 0, 1, 32'h80000000, 0, 0), 1, '{KIND_ACK, 4'd0, 17'd0, 16'd0, 1'b1});
    add(mk(ACT_LOAD_FULL, 0, 2, 32'h01000000, 0, 0), 1, '{KIND_ACK, 4'd0, 17'd0, 16'd0, 1'b1});
    add(mk(ACT_LOAD_FULL, 0, 3, 32'hFFFFFFFF, 0, 0), 1, '{KIND_ACK, 4'd0, 17'd0, 16'd0, 1'b1});
    add(mk(ACT_LOAD_FULL, 0, 4, 32'h00000000, 0, 0), 1, '{KIND_ACK, 4'd0, 17'd0, 16'd0, 1'b1});
    add(mk(ACT_LOAD_FULL, 0, 5, 32'h00800000, 0, 0), 1, '{KIND_ACK, 4'd0, 17'd0, 16'd0, 1'b1});
    // out-of-range axis: acknowledged, nothing written
    add(mk(ACT_LOAD_FULL, 4'hF, 3'd6, '1, 0, 0), 1, '{KIND_ACK, 4'hF, 17'd0, 16'd0, 1'b1});
    add(mk(ACT_LOAD_RCS, 4'd9, 3'd7, '1, 0, 0), 1, '{KIND_ACK, 4'd9, 17'd0, 16'd0, 1'b1});
    for (int a = 0; a < 6; a++)
      add(mk(ACT_LOAD_RCS, 0, 3'(a), (a == 0) ? 32'h01000000 : 32'h00400000, 0, 0), 1,
          '{KIND_ACK, 4'd0, 17'd0, 16'd0, 1'b1});
    add_cfg(REG_COUNT, 17'd1);
    add_cfg(REG_RCS, 17'h00001);
    add(mk(ACT_ALLOC_FULL, 0, 0, 0, 32'h7FFFFFFF, 0), -1, none);
    add(mk(ACT_ALLOC_FULL, 0, 0, 0, 32'h80000000, 0), -1, none);
    add(mk(ACT_ALLOC_RCS, 0, 0, 0, 32'h00008000, 0), -1, none);
    // period zero: phase never wraps, nothing fires
    add_cfg(REG_FRAC, 17'h10000);
    add_cfg(REG_PERIOD, 17'd0);
    add(mk(ACT_TICK, 0, 0, 0, 0, 16'd100), -1, none);
    // period one with full steps drives the phase into saturation
    add_cfg(REG_FRAC, 17'd0);
    add_cfg(REG_PERIOD, 17'd1);
    for (int k = 0; k < 3; k++) add(mk(ACT_TICK, 0, 0, 0, 0, 16'hFFFF), -1, none);

    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (rows[r]) begin
      if (rows[r].is_cfg) begin
        drain();
        cfg_write(rows[r].reg_sel, rows[r].reg_val);
      end else begin
        send_beat(rows[r].b, rows[r].ntyped, rows[r].typed);
        sender_gap();
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      cfg_write(REG_COUNT, 17'(counts[ph]));
      case (ph % 3)
        0: cfg_write(REG_RCS, 17'h0FFFF);
        1: cfg_write(REG_RCS, 17'h00000);
        default: cfg_write(REG_RCS, 17'($urandom_range(0, 16'hFFFF)));
      endcase
      case (ph % 4)
        0: cfg_write(REG_PERIOD, 17'd65535);
        1: cfg_write(REG_PERIOD, 17'($urandom_range(1, 2000)));
        2: cfg_write(REG_PERIOD, 17'd1);
        default: cfg_write(REG_PERIOD, 17'($urandom_range(1, 16'hFFFF)));
      endcase
      case (ph % 3)
        0: cfg_write(REG_FRAC, 17'd0);
        1: cfg_write(REG_FRAC, 17'h10000);
        default: cfg_write(REG_FRAC, 17'($urandom_range(0, 32'h10000)));
      endcase
      if (ph == 3) hold_req = 1;
      for (int k = 0; k < 26; k++) begin
        // pause mid-phase until every result is back
        if (ph == 5 && k == 13) begin
          in_valid <= 0;
          while (expected_results.size() != 0) @(posedge clk);
          @(posedge clk);
        end
        send_beat(next_beat(), -1, none);
        sender_gap();
      end
    end

    drain();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("thruster_allocation_pwm_unit verification clean");
    end else begin
      $display("thruster_allocation_pwm_unit verification failed");
    end
    $finish;
  end

endmodule
